// ===== hw/rtl/flha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_pkg
// shared types and codes for the free-list heap allocator
// ----------------------------------------------------------------------------
package flha_pkg;

  // command, fit policy and result codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } flha_status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SLOT,
    S_ASCAN,
    S_ACOMMIT,
    S_MATCH,
    S_FSCAN,
    S_FDECIDE,
    S_MV_RD,
    S_MV_WR,
    S_FWRITE,
    S_DONE
  } flha_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_SLOT,
    OP_ESCAN,
    OP_ACOMMIT,
    OP_MATCH,
    OP_DECIDE,
    OP_MV_RD,
    OP_MV_WR,
    OP_FWRITE,
    OP_SETRES,
    OP_EMIT
  } flha_op_t;

  typedef struct packed {
    flha_op_t     op;
    flha_status_t res_code;
  } flha_cmd_t;

  typedef struct packed {
    logic slot_found;
    logic slot_exh;
    logic scan_done;
    logic match_found;
    logic match_exh;
    logic dec_full;
    logic mv_none;
    logic out_busy;
  } flha_stat_t;

endpackage

// ===== hw/rtl/flha_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_in_if
// request channel: allocate or free transaction
// ----------------------------------------------------------------------------
interface flha_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] request_bytes;
  logic [1:0]  fit_policy;
  logic [11:0] release_offset;

  modport source (output valid, cmd, request_bytes, fit_policy, release_offset,
                  input ready);
  modport sink (input valid, cmd, request_bytes, fit_policy, release_offset,
                output ready);
endinterface

// ===== hw/rtl/flha_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_out_if
// result channel: status and granted payload offset
// ----------------------------------------------------------------------------
interface flha_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] payload_offset;

  modport source (output valid, status, payload_offset, input ready);
  modport sink (input valid, status, payload_offset, output ready);
endinterface

// ===== hw/rtl/flha_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module flha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/flha_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_ctrl
// sequencer for allocate and free transactions
// ----------------------------------------------------------------------------
module flha_ctrl import flha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  flha_stat_t stat_i,
  output flha_cmd_t  cmd_o
);

  flha_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_o.op        = OP_NONE;
    cmd_o.res_code  = ST_OK;
    in_ready        = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd_o.op  = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.op  = OP_LOAD;
          state_nxt = (in_cmd == CMD_FREE) ? S_MATCH : S_SLOT;
        end
      end
      S_SLOT: begin
        if (stat_i.slot_found) begin
          state_nxt = S_ASCAN;
        end else if (stat_i.slot_exh) begin
          cmd_o.op       = OP_SETRES;
          cmd_o.res_code = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          cmd_o.op = OP_SLOT;
        end
      end
      S_ASCAN: begin
        if (stat_i.scan_done) begin
          state_nxt = S_ACOMMIT;
        end else begin
          cmd_o.op = OP_ESCAN;
        end
      end
      S_ACOMMIT: begin
        cmd_o.op  = OP_ACOMMIT;
        state_nxt = S_DONE;
      end
      S_MATCH: begin
        if (stat_i.match_found) begin
          state_nxt = S_FSCAN;
        end else if (stat_i.match_exh) begin
          cmd_o.op       = OP_SETRES;
          cmd_o.res_code = ST_BADFREE;
          state_nxt      = S_DONE;
        end else begin
          cmd_o.op = OP_MATCH;
        end
      end
      S_FSCAN: begin
        if (stat_i.scan_done) begin
          state_nxt = S_FDECIDE;
        end else begin
          cmd_o.op = OP_ESCAN;
        end
      end
      S_FDECIDE: begin
        cmd_o.op  = OP_DECIDE;
        state_nxt = stat_i.dec_full ? S_DONE : S_MV_RD;
      end
      S_MV_RD: begin
        if (stat_i.mv_none) begin
          state_nxt = S_FWRITE;
        end else begin
          cmd_o.op  = OP_MV_RD;
          state_nxt = S_MV_WR;
        end
      end
      S_MV_WR: begin
        cmd_o.op  = OP_MV_WR;
        state_nxt = S_MV_RD;
      end
      S_FWRITE: begin
        cmd_o.op  = OP_FWRITE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op  = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

// ===== hw/rtl/flha_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_dp
// extent and live-block tables, scans, split, merge and table shifts
// ----------------------------------------------------------------------------
module flha_dp import flha_pkg::*; #(
  parameter int ARENA_BYTES         = 4096,
  parameter int MAX_EXTENTS         = 16,
  parameter int MAX_LIVE            = 16,
  parameter int EXTENT_HEADER_BYTES = 16,
  parameter int BLOCK_HEADER_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_cmd,
  input  logic [11:0] in_request_bytes,
  input  logic [1:0]  in_fit_policy,
  input  logic [11:0] in_release_offset,
  input  flha_cmd_t   cmd_i,
  output flha_stat_t  stat_o,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [11:0] out_payload_offset
);

  localparam int AW = ($clog2(ARENA_BYTES) + 1 > 14) ? $clog2(ARENA_BYTES) + 1 : 14;
  localparam int EW = 2 * AW;
  localparam int EI = $clog2(MAX_EXTENTS);
  localparam int EC = $clog2(MAX_EXTENTS + 1);
  localparam int LI = $clog2(MAX_LIVE);
  localparam int LC = $clog2(MAX_LIVE + 1);

  localparam logic [AW-1:0] EH       = AW'(EXTENT_HEADER_BYTES);
  localparam logic [AW-1:0] BH       = AW'(BLOCK_HEADER_BYTES);
  localparam logic [AW-1:0] ARENA_SZ = AW'(ARENA_BYTES - EXTENT_HEADER_BYTES);
  localparam logic [EC-1:0] EXT_MAX  = EC'(MAX_EXTENTS);
  localparam logic [LC-1:0] LIVE_MAX = LC'(MAX_LIVE);

  // request
  logic          cmd_r;
  logic [AW-1:0] demand_r;
  logic [1:0]    pol_r;
  logic [11:0]   off_r;

  // persistent state
  logic [EC-1:0]       count_r;
  logic [AW-1:0]       rover_r;
  logic [MAX_LIVE-1:0] live_valid_r;

  // scan counters
  logic [LC-1:0] l_idx_r;
  logic          l_vld_r;
  logic [LI-1:0] l_tag_r;
  logic [EC-1:0] e_idx_r;
  logic          e_vld_r;
  logic [EI-1:0] e_tag_r;

  // allocate scan results
  logic          slot_found_r;
  logic [LI-1:0] slot_r;
  logic          pick_v_r, hit_v_r;
  logic [EI-1:0] pick_idx_r, hit_idx_r;
  logic [AW-1:0] pick_st_r, pick_sz_r, hit_st_r, hit_sz_r;

  // free scan results
  logic          m_found_r;
  logic [LI-1:0] m_idx_r;
  logic [AW-1:0] fs_st_r, fs_tot_r;
  logic          k_found_r;
  logic [EI-1:0] k_idx_r;
  logic [AW-1:0] nk_st_r, nk_sz_r, prev_st_r, prev_sz_r;
  logic          merge_prev_r, merge_next_r;
  logic          mv_down_r;
  logic [EC-1:0] mv_n_r, mv_dst_r;

  // result
  flha_status_t  res_st_r;
  logic [11:0]   res_off_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [11:0]   out_offset_r;

  // ram ports
  logic          ext_we, live_we;
  logic [EI-1:0] ext_waddr, ext_raddr;
  logic [LI-1:0] live_waddr, live_raddr;
  logic [EW-1:0] ext_wdata, ext_rdata, live_wdata, live_rdata;

  flha_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  flha_ram #(.WIDTH(EW), .DEPTH(MAX_LIVE)) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  logic [AW-1:0] ext_rd_st, ext_rd_sz, live_rd_st, live_pay;
  logic [AW-1:0] demand_raw, demand_in;
  logic [EC-1:0] k_w, km1_w, mv_src;
  logic          prev_touch, next_touch, full_w, dec_full;
  logic          use_hit;
  logic [EI-1:0] sel_idx;
  logic [AW-1:0] sel_st, sel_sz, sel_pay;
  logic          fit, pick_upd, hit_upd;

  assign ext_rd_st  = ext_rdata[EW-1:AW];
  assign ext_rd_sz  = ext_rdata[AW-1:0];
  assign live_rd_st = live_rdata[EW-1:AW];
  assign live_pay   = live_rd_st + BH;

  assign demand_raw = AW'(in_request_bytes) + BH;
  assign demand_in  = (demand_raw < EH) ? EH : demand_raw;

  // insertion point k: first extent above the freed block, or the count
  assign k_w        = k_found_r ? EC'(k_idx_r) : count_r;
  assign km1_w      = k_w - EC'(1);
  assign prev_touch = (k_w != '0) && (prev_st_r + EH + prev_sz_r == fs_st_r);
  assign next_touch = k_found_r && (fs_st_r + fs_tot_r == nk_st_r);
  assign full_w     = (count_r == EXT_MAX);
  assign dec_full   = !prev_touch && !next_touch && full_w;
  assign mv_src     = mv_down_r ? mv_dst_r + EC'(1) : mv_dst_r - EC'(1);

  assign use_hit = (pol_r == POL_NEXT) && hit_v_r;
  assign sel_idx = use_hit ? hit_idx_r : pick_idx_r;
  assign sel_st  = use_hit ? hit_st_r : pick_st_r;
  assign sel_sz  = use_hit ? hit_sz_r : pick_sz_r;
  assign sel_pay = sel_st + BH;

  assign fit      = ext_rd_sz >= demand_r;
  assign pick_upd = fit && (!pick_v_r ||
                            (pol_r == POL_BEST && ext_rd_sz < pick_sz_r) ||
                            (pol_r == POL_WORST && ext_rd_sz > pick_sz_r));
  assign hit_upd  = fit && !hit_v_r && (ext_rd_st >= rover_r);

  // ram address and write control
  always_comb begin
    ext_we     = 1'b0;
    ext_waddr  = '0;
    ext_wdata  = '0;
    ext_raddr  = e_idx_r[EI-1:0];
    live_we    = 1'b0;
    live_waddr = slot_r;
    live_wdata = {sel_st, demand_r};
    live_raddr = l_idx_r[LI-1:0];
    case (cmd_i.op)
      OP_INIT: begin
        ext_we    = 1'b1;
        ext_wdata = {{AW{1'b0}}, ARENA_SZ};
      end
      OP_ACOMMIT: begin
        if (pick_v_r) begin
          ext_we    = 1'b1;
          ext_waddr = sel_idx;
          ext_wdata = {sel_st + demand_r, sel_sz - demand_r};
          live_we   = 1'b1;
        end
      end
      OP_MV_RD: begin
        ext_raddr = mv_src[EI-1:0];
      end
      OP_MV_WR: begin
        ext_we    = 1'b1;
        ext_waddr = mv_dst_r[EI-1:0];
        ext_wdata = ext_rdata;
      end
      OP_FWRITE: begin
        ext_we = 1'b1;
        if (merge_prev_r && merge_next_r) begin
          ext_waddr = km1_w[EI-1:0];
          ext_wdata = {prev_st_r, prev_sz_r + fs_tot_r + EH + nk_sz_r};
        end else if (merge_prev_r) begin
          ext_waddr = km1_w[EI-1:0];
          ext_wdata = {prev_st_r, prev_sz_r + fs_tot_r};
        end else if (merge_next_r) begin
          ext_waddr = k_w[EI-1:0];
          ext_wdata = {fs_st_r, nk_sz_r + fs_tot_r};
        end else begin
          ext_waddr = k_w[EI-1:0];
          ext_wdata = {fs_st_r, fs_tot_r - EH};
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= EC'(1);
      rover_r      <= '0;
      live_valid_r <= '0;
      out_valid_r  <= 1'b0;
      l_vld_r      <= 1'b0;
      e_vld_r      <= 1'b0;
    end else begin
      // result register: load on emit, drain on acceptance
      if (cmd_i.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          l_vld_r <= 1'b0;
          e_vld_r <= 1'b0;
        end
        OP_MATCH: begin
          l_vld_r <= (l_idx_r != LIVE_MAX) && !m_found_r;
        end
        OP_ESCAN: begin
          e_vld_r <= (e_idx_r != count_r);
        end
        OP_ACOMMIT: begin
          if (pick_v_r) begin
            live_valid_r[slot_r] <= 1'b1;
            if (pol_r == POL_NEXT) begin
              rover_r <= sel_st + demand_r;
            end
          end else if (pol_r == POL_NEXT) begin
            rover_r <= '0;
          end
        end
        OP_FWRITE: begin
          live_valid_r[m_idx_r] <= 1'b0;
          if (merge_prev_r && merge_next_r) begin
            count_r <= count_r - EC'(1);
            if (rover_r == nk_st_r) begin
              rover_r <= prev_st_r;
            end
          end else if (merge_next_r) begin
            if (rover_r == nk_st_r) begin
              rover_r <= fs_st_r;
            end
          end else if (!merge_prev_r) begin
            count_r <= count_r + EC'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_r        <= in_cmd;
        demand_r     <= demand_in;
        pol_r        <= in_fit_policy;
        off_r        <= in_release_offset;
        l_idx_r      <= '0;
        e_idx_r      <= '0;
        slot_found_r <= 1'b0;
        pick_v_r     <= 1'b0;
        hit_v_r      <= 1'b0;
        m_found_r    <= 1'b0;
        k_found_r    <= 1'b0;
      end
      OP_SLOT: begin
        if (!live_valid_r[l_idx_r[LI-1:0]]) begin
          slot_found_r <= 1'b1;
          slot_r       <= l_idx_r[LI-1:0];
        end else begin
          l_idx_r <= l_idx_r + LC'(1);
        end
      end
      OP_MATCH: begin
        if (l_idx_r != LIVE_MAX && !m_found_r) begin
          l_tag_r <= l_idx_r[LI-1:0];
          l_idx_r <= l_idx_r + LC'(1);
        end
        if (l_vld_r && !m_found_r && live_valid_r[l_tag_r] &&
            live_pay[11:0] == off_r) begin
          m_found_r <= 1'b1;
          m_idx_r   <= l_tag_r;
          fs_st_r   <= live_rd_st;
          fs_tot_r  <= live_rdata[AW-1:0];
        end
      end
      OP_ESCAN: begin
        if (e_idx_r != count_r) begin
          e_tag_r <= e_idx_r[EI-1:0];
          e_idx_r <= e_idx_r + EC'(1);
        end
        if (e_vld_r) begin
          if (cmd_r == CMD_ALLOC) begin
            if (pick_upd) begin
              pick_v_r   <= 1'b1;
              pick_idx_r <= e_tag_r;
              pick_st_r  <= ext_rd_st;
              pick_sz_r  <= ext_rd_sz;
            end
            if (hit_upd) begin
              hit_v_r   <= 1'b1;
              hit_idx_r <= e_tag_r;
              hit_st_r  <= ext_rd_st;
              hit_sz_r  <= ext_rd_sz;
            end
          end else if (!k_found_r) begin
            if (ext_rd_st > fs_st_r) begin
              k_found_r <= 1'b1;
              k_idx_r   <= e_tag_r;
              nk_st_r   <= ext_rd_st;
              nk_sz_r   <= ext_rd_sz;
            end else begin
              prev_st_r <= ext_rd_st;
              prev_sz_r <= ext_rd_sz;
            end
          end
        end
      end
      OP_ACOMMIT: begin
        res_st_r  <= pick_v_r ? ST_OK : ST_NOFIT;
        res_off_r <= pick_v_r ? sel_pay[11:0] : 12'd0;
      end
      OP_DECIDE: begin
        merge_prev_r <= prev_touch;
        merge_next_r <= next_touch;
        if (prev_touch && next_touch) begin
          mv_down_r <= 1'b1;
          mv_n_r    <= count_r - k_w - EC'(1);
          mv_dst_r  <= k_w;
        end else if (!prev_touch && !next_touch && !full_w) begin
          mv_down_r <= 1'b0;
          mv_n_r    <= count_r - k_w;
          mv_dst_r  <= count_r;
        end else begin
          mv_down_r <= 1'b0;
          mv_n_r    <= '0;
          mv_dst_r  <= count_r;
        end
        res_st_r  <= ST_FULL;
        res_off_r <= 12'd0;
      end
      OP_MV_WR: begin
        mv_dst_r <= mv_src;
        mv_n_r   <= mv_n_r - EC'(1);
      end
      OP_FWRITE: begin
        res_st_r  <= ST_OK;
        res_off_r <= 12'd0;
      end
      OP_SETRES: begin
        res_st_r  <= cmd_i.res_code;
        res_off_r <= 12'd0;
      end
      OP_EMIT: begin
        out_status_r <= res_st_r;
        out_offset_r <= res_off_r;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.slot_found  = slot_found_r;
  assign stat_o.slot_exh    = (l_idx_r == LIVE_MAX);
  assign stat_o.scan_done   = (e_idx_r == count_r) && !e_vld_r;
  assign stat_o.match_found = m_found_r;
  assign stat_o.match_exh   = (l_idx_r == LIVE_MAX) && !l_vld_r;
  assign stat_o.dec_full    = dec_full;
  assign stat_o.mv_none     = (mv_n_r == '0);
  assign stat_o.out_busy    = out_valid_r && !out_ready;

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_offset_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= EXT_MAX)
    else $error("extent count out of range");

  a_alloc_marks_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.op == OP_ACOMMIT && pick_v_r |=> live_valid_r[$past(slot_r)])
    else $error("granted block not marked live");

  a_free_clears_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.op == OP_FWRITE |=> !live_valid_r[$past(m_idx_r)])
    else $error("freed block still marked live");

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_offset_r == 12'd0)
    else $error("failed transaction carries an offset");

endmodule

// ===== hw/rtl/free_list_heap_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_heap_allocator_unit
// free-list allocator over a fixed arena with first, best, worst and next fit
// ----------------------------------------------------------------------------
// One transaction is handled at a time and every transaction gives exactly one
// result. Free extents live in an address-ordered ram of MAX_EXTENTS entries,
// live blocks in a second ram of MAX_LIVE entries with a valid flop per entry.
// An allocate makes a one-per-cycle walk of the live valid bits for a free
// slot, then a pipelined read of every extent through the ram read port, then
// a commit step. A free shifts every extent entry that has to move (a merge of
// both neighbours or a fresh entry), and each shift is a read then a write
// through the single read port of the extent ram. After reset the block seeds
// the extent table with the whole arena before taking requests.
// A result waiting on the output does not stop the next request being taken;
// only its own result has to wait for the output register to drain.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_unit import flha_pkg::*; #(
  parameter int ARENA_BYTES         = 4096,
  parameter int MAX_EXTENTS         = 16,
  parameter int MAX_LIVE            = 16,
  parameter int EXTENT_HEADER_BYTES = 16,
  parameter int BLOCK_HEADER_BYTES  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  flha_in_if.sink    in_tx,
  flha_out_if.source out_tx
);

  // command and status between sequencer and datapath
  flha_cmd_t  ctl_cmd;
  flha_stat_t dp_stat;

  // sequencer: owns the request handshake and walks each transaction
  flha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tx.valid),
    .in_cmd   (in_tx.cmd),
    .in_ready (in_tx.ready),
    .stat_i   (dp_stat),
    .cmd_o    (ctl_cmd)
  );

  // datapath: tables, scans, split and merge, result register
  flha_dp #(
    .ARENA_BYTES         (ARENA_BYTES),
    .MAX_EXTENTS         (MAX_EXTENTS),
    .MAX_LIVE            (MAX_LIVE),
    .EXTENT_HEADER_BYTES (EXTENT_HEADER_BYTES),
    .BLOCK_HEADER_BYTES  (BLOCK_HEADER_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_tx.cmd),
    .in_request_bytes   (in_tx.request_bytes),
    .in_fit_policy      (in_tx.fit_policy),
    .in_release_offset  (in_tx.release_offset),
    .cmd_i              (ctl_cmd),
    .stat_o             (dp_stat),
    .out_valid          (out_tx.valid),
    .out_ready          (out_tx.ready),
    .out_status         (out_tx.status),
    .out_payload_offset (out_tx.payload_offset)
  );

endmodule

// ===== sim/flha_heap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_heap_checker
// watches both channels, tracks the free-extent and live-block tables of the
// allocator and compares every result with the predicted one
// ----------------------------------------------------------------------------
module flha_heap_checker import flha_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  flha_in_if   in_mon,
  flha_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int EXT_SLOTS  = 16;
  localparam int LIVE_SLOTS = 16;
  localparam int EXT_HDR    = 16;
  localparam int BLK_HDR    = 8;
  localparam int ARENA      = 4096;

  typedef struct packed {
    flha_status_t status;
    logic [11:0]  payload_offset;
  } heap_result_t;

  logic [11:0] ext_start [EXT_SLOTS];
  logic [11:0] ext_size  [EXT_SLOTS];
  int          ext_count;
  logic [11:0] blk_start [LIVE_SLOTS];
  logic [11:0] blk_size  [LIVE_SLOTS];
  logic        blk_live  [LIVE_SLOTS];
  logic [11:0] rover;

  heap_result_t result_q[$];

  assign pending = result_q.size();

  task automatic report(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int choose_extent(input logic [1:0] pol, input int unsigned need);
    int pick;
    pick = -1;
    for (int i = 0; i < ext_count; i++) begin
      if (ext_size[i] < need) continue;
      case (pol)
        POL_BEST: if (pick < 0 || ext_size[i] < ext_size[pick]) pick = i;
        POL_WORST: if (pick < 0 || ext_size[i] > ext_size[pick]) pick = i;
        POL_NEXT: begin
          if (ext_start[i] >= rover) return i;
          if (pick < 0) pick = i;
        end
        default: return i;
      endcase
    end
    return pick;
  endfunction

  function automatic flha_status_t grant(input int unsigned n, input logic [1:0] pol,
                                         output logic [11:0] pay);
    int unsigned need;
    int          slot;
    int          k;
    need = n + BLK_HDR;
    slot = -1;
    pay  = '0;
    if (need < EXT_HDR) need = EXT_HDR;
    for (int j = LIVE_SLOTS - 1; j >= 0; j--)
      if (!blk_live[j]) slot = j;
    if (slot < 0) return ST_FULL;
    k = choose_extent(pol, need);
    if (k < 0) begin
      if (pol == POL_NEXT) rover = '0;
      return ST_NOFIT;
    end
    blk_start[slot] = ext_start[k];
    blk_size[slot]  = need;
    blk_live[slot]  = 1'b1;
    pay = ext_start[k] + BLK_HDR;
    ext_start[k] = ext_start[k] + need;
    ext_size[k]  = ext_size[k] - need;
    if (pol == POL_NEXT) rover = ext_start[k];
    return ST_OK;
  endfunction

  function automatic flha_status_t release_block(input logic [11:0] off);
    int          slot;
    int          k;
    int unsigned s;
    int unsigned total;
    bit          lo_touch;
    bit          hi_touch;
    slot = -1;
    for (int j = LIVE_SLOTS - 1; j >= 0; j--)
      if (blk_live[j] && 12'(blk_start[j] + BLK_HDR) == off) slot = j;
    if (slot < 0) return ST_BADFREE;
    s     = blk_start[slot];
    total = blk_size[slot];
    k = ext_count;
    for (int i = ext_count - 1; i >= 0; i--)
      if (ext_start[i] > s) k = i;
    lo_touch = k > 0 && (int'(ext_start[k-1]) + EXT_HDR + int'(ext_size[k-1]) == s);
    hi_touch = k < ext_count && (s + total == int'(ext_start[k]));
    if (lo_touch && hi_touch) begin
      ext_size[k-1] = ext_size[k-1] + total + EXT_HDR + ext_size[k];
      if (rover == ext_start[k]) rover = ext_start[k-1];
      for (int i = k; i + 1 < ext_count; i++) begin
        ext_start[i] = ext_start[i+1];
        ext_size[i]  = ext_size[i+1];
      end
      ext_count--;
    end else if (lo_touch) begin
      ext_size[k-1] = ext_size[k-1] + total;
    end else if (hi_touch) begin
      if (rover == ext_start[k]) rover = s;
      ext_start[k] = s;
      ext_size[k]  = ext_size[k] + total;
    end else begin
      if (ext_count >= EXT_SLOTS) return ST_FULL;
      for (int i = ext_count; i > k; i--) begin
        ext_start[i] = ext_start[i-1];
        ext_size[i]  = ext_size[i-1];
      end
      ext_start[k] = s;
      ext_size[k]  = total - EXT_HDR;
      ext_count++;
    end
    blk_live[slot] = 1'b0;
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    heap_result_t got;
    logic [11:0]  pay;
    if (!rst_n) begin
      for (int i = 0; i < EXT_SLOTS; i++) begin
        ext_start[i] = '0;
        ext_size[i]  = '0;
      end
      for (int i = 0; i < LIVE_SLOTS; i++) begin
        blk_start[i] = '0;
        blk_size[i]  = '0;
        blk_live[i]  = 1'b0;
      end
      ext_size[0] = ARENA - EXT_HDR;
      ext_count   = 1;
      rover       = '0;
      result_q.delete();
    end else begin
      // result side first: a result can never belong to this cycle's request
      if (out_mon.valid && out_mon.ready) begin
        got.status         = flha_status_t'(out_mon.status);
        got.payload_offset = out_mon.payload_offset;
        if (result_q.size() == 0) begin
          report($sformatf("unexpected result status %0d offset %0d",
                           got.status, got.payload_offset));
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", out_mon.status, want.status));
          if (got.payload_offset !== want.payload_offset)
            report($sformatf("payload_offset %0d, want %0d",
                             out_mon.payload_offset, want.payload_offset));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pay = '0;
        if (in_mon.cmd == CMD_ALLOC)
          want.status = grant(in_mon.request_bytes, in_mon.fit_policy, pay);
        else
          want.status = release_block(in_mon.release_offset);
        want.payload_offset = (want.status == ST_OK) ? pay : '0;
        result_q.push_back(want);
      end
    end
  end

  initial fail_count = 0;

endmodule

// ===== sim/free_list_heap_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_heap_allocator_unit_test
// drives allocate and free transactions into the heap allocator
// ----------------------------------------------------------------------------
// a directed opening walks the merge cases, zero remainder, next-fit rover,
// bad frees and a full live table; then random traffic mixes frees of granted
// offsets with allocates of mostly small sizes under random back-pressure.
// the checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_unit_test;
  import flha_pkg::*;

  localparam logic [1:0] POL_FIRST = 2'd2;
  localparam int RANDOM_TXNS = 925;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  // calm phases draw no gaps on either side
  bit   calm;
  // set by the stimulus to ask the result side for one long hold-off
  bit   hold_req;

  // payload offsets handed out and not yet freed by the stimulus
  logic [11:0] granted_q[$];

  flha_in_if  in_tx ();
  flha_out_if out_tx ();

  free_list_heap_allocator_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_tx  (in_tx),
    .out_tx (out_tx)
  );

  flha_heap_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_tx),
    .out_mon    (out_tx),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #20ms;
    $display("free_list_heap_allocator_unit verification failed");
    $finish;
  end

  // collect granted offsets so later frees mostly hit live blocks
  always @(posedge clk) begin
    if (rst_n && out_tx.valid && out_tx.ready && out_tx.status == ST_OK &&
        out_tx.payload_offset != 12'd0)
      granted_q.push_back(out_tx.payload_offset);
  end

  // result side: random stalls per transaction, plus one long hold-off on request
  initial begin
    int stall;
    out_tx.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tx.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
          out_tx.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tx.ready <= 1'b1;
      do @(posedge clk); while (!out_tx.valid);
    end
  end

  // one transaction: optional gap, then hold valid until the block takes it
  task automatic send_txn(input logic cmd, input logic [11:0] nbytes,
                          input logic [1:0] pol, input logic [11:0] off);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_tx.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tx.cmd            <= cmd;
    in_tx.request_bytes  <= nbytes;
    in_tx.fit_policy     <= pol;
    in_tx.release_offset <= off;
    in_tx.valid          <= 1'b1;
    do @(posedge clk); while (!in_tx.ready);
  endtask

  task automatic alloc_txn(input logic [11:0] nbytes, input logic [1:0] pol);
    send_txn(CMD_ALLOC, nbytes, pol, 12'($urandom));
  endtask

  task automatic free_txn(input logic [11:0] off);
    send_txn(CMD_FREE, 12'($urandom), 2'($urandom), off);
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    in_tx.valid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int          pick;
    int          roll;
    logic [11:0] nbytes;
    rst_n                = 1'b0;
    calm                 = 1'b0;
    hold_req             = 1'b0;
    in_tx.valid          = 1'b0;
    in_tx.cmd            = CMD_ALLOC;
    in_tx.request_bytes  = '0;
    in_tx.fit_policy     = POL_BEST;
    in_tx.release_offset = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every policy on a fresh arena, smallest size raised to a full header
    alloc_txn(12'd0, POL_BEST);
    alloc_txn(12'd8, POL_FIRST);
    alloc_txn(12'd24, POL_WORST);
    alloc_txn(12'd40, POL_NEXT);
    // isolated block becomes a zero-size extent, then merges on each side
    free_txn(12'd24);
    free_txn(12'd8);
    free_txn(12'd40);
    free_txn(12'd72);
    // double free and offsets never granted
    free_txn(12'd8);
    free_txn(12'd4095);
    free_txn(12'd0);
    // too large, then an exact fit leaving a zero remainder
    alloc_txn(12'd4095, POL_WORST);
    alloc_txn(12'd4072, POL_FIRST);
    alloc_txn(12'd0, POL_NEXT);
    free_txn(12'd8);
    // next fit from the rover, then one too large that resets the rover
    alloc_txn(12'd2000, POL_NEXT);
    alloc_txn(12'd3000, POL_NEXT);
    // fill the live table, one more reports full
    idle_until_drained();
    granted_q.delete();
    for (int i = 0; i < 15; i++) alloc_txn(12'd100, 2'(i));
    alloc_txn(12'd1, POL_BEST);

    // block fills while results are held back
    idle_until_drained();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) free_txn(granted_q.size() > 0 ? granted_q.pop_front()
                                                          : 12'd8);
    idle_until_drained();

    for (int t = 0; t < RANDOM_TXNS; t++) begin
      if (t % 150 == 0) calm = ($urandom_range(0, 2) == 0);
      if (t == 450) idle_until_drained();
      roll = $urandom_range(0, 99);
      if (roll < 45 && granted_q.size() > 0) begin
        pick = $urandom_range(0, granted_q.size() - 1);
        free_txn(granted_q[pick]);
        granted_q.delete(pick);
      end else if (roll < 52) begin
        free_txn(12'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       nbytes = 12'($urandom);
          1, 2:    nbytes = 12'($urandom_range(0, 1000));
          default: nbytes = 12'($urandom_range(0, 120));
        endcase
        alloc_txn(nbytes, 2'($urandom));
      end
    end

    @(negedge clk);
    in_tx.valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("free_list_heap_allocator_unit verification clean");
    end else begin
      $display("free_list_heap_allocator_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/flha_pkg.sv
hw/rtl/flha_in_if.sv
hw/rtl/flha_out_if.sv
hw/rtl/flha_ram.sv
hw/rtl/flha_ctrl.sv
hw/rtl/flha_dp.sv
hw/rtl/free_list_heap_allocator_unit.sv
sim/flha_heap_checker.sv
sim/free_list_heap_allocator_unit_test.sv
